// File: rtl/pcd_pkg.sv
// Package with the constants, payload types and state encoding of the cycle decomposer.
`default_nettype none
package pcd_pkg;

    localparam int ELEMENTS    = 16;
    localparam int ELEM_W      = 4;
    localparam int IDX_W       = $clog2(ELEMENTS);
    localparam int CNT_W       = $clog2(ELEMENTS + 1);
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef logic [ELEM_W-1:0] t_elem;

    typedef struct packed {
        t_elem element;
        t_elem image;
        logic  load_last;
    } t_in_data;

    typedef struct packed {
        t_elem cycle_value;
        logic  cycle_end;
        logic  run_last;
        logic  not_permutation;
    } t_out_data;

    typedef struct packed {
        t_elem element;
        t_elem image;
        logic  run;
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_READ,
        ST_STEP,
        ST_FINISH
    } t_state;

endpackage
`default_nettype wire

// File: rtl/pcd_front.sv
// Front end: accepts input transactions, classifies them and queues them as commands.
`default_nettype none
module pcd_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire pcd_pkg::t_in_data i_in_data,
    output logic                   o_in_ready,
    output logic                   o_cmd_valid,
    output pcd_pkg::t_cmd          o_cmd,
    input  wire logic              i_cmd_ready
);

    pcd_pkg::t_cmd                 r_queue [pcd_pkg::QUEUE_DEPTH];
    logic [pcd_pkg::QPTR_W-1:0]    r_wr_ptr;
    logic [pcd_pkg::QPTR_W-1:0]    r_rd_ptr;
    logic [pcd_pkg::QCNT_W-1:0]    r_count;
    logic [pcd_pkg::QPTR_W-1:0]    n_wr_ptr;
    logic [pcd_pkg::QPTR_W-1:0]    n_rd_ptr;
    logic [pcd_pkg::QCNT_W-1:0]    n_count;
    logic                          push;
    logic                          pop;
    pcd_pkg::t_cmd                 cmd_in;

    always_comb begin
        cmd_in.element = i_in_data.element;
        cmd_in.image   = i_in_data.image;
        cmd_in.run     = i_in_data.load_last;
    end

    assign o_in_ready  = (r_count != pcd_pkg::QCNT_W'(pcd_pkg::QUEUE_DEPTH));
    assign o_cmd_valid = (r_count != '0);
    assign o_cmd       = r_queue[r_rd_ptr];
    assign push        = i_in_valid && o_in_ready;
    assign pop         = o_cmd_valid && i_cmd_ready;

    always_comb begin
        n_wr_ptr = push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = pop ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_queue[r_wr_ptr] <= cmd_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule
`default_nettype wire

// File: rtl/pcd_back.sv
// Back end: image table, scan and walk sequencer, and the result output register.
`default_nettype none
module pcd_back (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cmd_valid,
    input  wire pcd_pkg::t_cmd      i_cmd,
    output logic                    o_cmd_ready,
    output logic                    o_out_valid,
    output pcd_pkg::t_out_data      o_out_data,
    input  wire logic               i_out_ready
);

    pcd_pkg::t_state                r_state;
    pcd_pkg::t_state                n_state;
    pcd_pkg::t_elem                 r_mem [pcd_pkg::ELEMENTS];
    pcd_pkg::t_elem                 r_rd;
    logic [pcd_pkg::ELEMENTS-1:0]   r_moved;
    logic [pcd_pkg::ELEMENTS-1:0]   n_moved;
    logic [pcd_pkg::ELEMENTS-1:0]   r_seen;
    logic [pcd_pkg::ELEMENTS-1:0]   n_seen;
    logic [pcd_pkg::CNT_W-1:0]      r_scan;
    logic [pcd_pkg::CNT_W-1:0]      n_scan;
    logic [pcd_pkg::CNT_W-1:0]      r_count;
    logic [pcd_pkg::CNT_W-1:0]      n_count;
    pcd_pkg::t_elem                 r_pos;
    pcd_pkg::t_elem                 n_pos;
    pcd_pkg::t_elem                 r_start;
    pcd_pkg::t_elem                 n_start;
    logic                           r_pend_valid;
    logic                           n_pend_valid;
    pcd_pkg::t_out_data             r_pend;
    pcd_pkg::t_out_data             n_pend;
    logic                           r_out_valid;
    logic                           n_out_valid;
    pcd_pkg::t_out_data             r_out;
    pcd_pkg::t_out_data             n_out;
    logic                           mem_we;
    logic                           out_free;
    logic                           push;
    logic                           push_last;
    pcd_pkg::t_elem                 next_elem;
    logic [pcd_pkg::IDX_W-1:0]      scan_idx;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign out_free    = !r_out_valid || i_out_ready;
    assign scan_idx    = r_scan[pcd_pkg::IDX_W-1:0];
    assign next_elem   = r_moved[r_pos[pcd_pkg::IDX_W-1:0]] ? r_rd : r_pos;

    always_comb begin
        n_state      = r_state;
        n_moved      = r_moved;
        n_seen       = r_seen;
        n_scan       = r_scan;
        n_count      = r_count;
        n_pos        = r_pos;
        n_start      = r_start;
        n_pend_valid = r_pend_valid;
        n_pend       = r_pend;
        mem_we       = 1'b0;
        o_cmd_ready  = 1'b0;
        push         = 1'b0;
        push_last    = 1'b0;
        unique case (r_state)
            pcd_pkg::ST_IDLE: begin
                o_cmd_ready = 1'b1;
                if (i_cmd_valid) begin
                    mem_we = 1'b1;
                    n_moved[i_cmd.element[pcd_pkg::IDX_W-1:0]] = (i_cmd.image != i_cmd.element);
                    if (i_cmd.run) begin
                        n_state = pcd_pkg::ST_SCAN;
                    end
                end
            end
            pcd_pkg::ST_SCAN: begin
                if (r_scan == pcd_pkg::CNT_W'(pcd_pkg::ELEMENTS)) begin
                    n_state = pcd_pkg::ST_FINISH;
                end else if (r_moved[scan_idx] && !r_seen[scan_idx]) begin
                    n_start = pcd_pkg::ELEM_W'(scan_idx);
                    n_pos   = pcd_pkg::ELEM_W'(scan_idx);
                    n_state = pcd_pkg::ST_READ;
                end else begin
                    n_scan = r_scan + 1'b1;
                end
            end
            pcd_pkg::ST_READ: begin
                n_state = pcd_pkg::ST_STEP;
            end
            pcd_pkg::ST_STEP: begin
                if (!r_pend_valid || out_free) begin
                    push                            = r_pend_valid;
                    n_seen[r_pos[pcd_pkg::IDX_W-1:0]] = 1'b1;
                    n_count                         = r_count + 1'b1;
                    n_pend_valid                    = 1'b1;
                    n_pend.cycle_value              = r_pos;
                    n_pend.cycle_end                = 1'b0;
                    n_pend.run_last                 = 1'b0;
                    n_pend.not_permutation          = 1'b0;
                    if (next_elem == r_start) begin
                        n_pend.cycle_end = 1'b1;
                        n_scan           = r_scan + 1'b1;
                        n_state          = pcd_pkg::ST_SCAN;
                    end else if (r_count >= pcd_pkg::CNT_W'(pcd_pkg::ELEMENTS - 1)) begin
                        n_pend.not_permutation = 1'b1;
                        n_state                = pcd_pkg::ST_FINISH;
                    end else begin
                        n_pos   = next_elem;
                        n_state = pcd_pkg::ST_READ;
                    end
                end
            end
            pcd_pkg::ST_FINISH: begin
                if (!r_pend_valid || out_free) begin
                    push         = r_pend_valid;
                    push_last    = 1'b1;
                    n_pend_valid = 1'b0;
                    n_moved      = '0;
                    n_seen       = '0;
                    n_scan       = '0;
                    n_count      = '0;
                    n_pos        = '0;
                    n_state      = pcd_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = pcd_pkg::ST_IDLE;
            end
        endcase

        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (push) begin
            n_out_valid  = 1'b1;
            n_out        = r_pend;
            n_out.run_last = push_last;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[i_cmd.element[pcd_pkg::IDX_W-1:0]] <= i_cmd.image;
        end
        r_rd <= r_mem[r_pos[pcd_pkg::IDX_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pcd_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_moved      <= '0;
            r_seen       <= '0;
            r_scan       <= '0;
            r_count      <= '0;
            r_pos        <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_moved      <= n_moved;
            r_seen       <= n_seen;
            r_scan       <= n_scan;
            r_count      <= n_count;
            r_pos        <= n_pos;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_start <= n_start;
        r_pend  <= n_pend;
        r_out   <= n_out;
    end

    a_idle_no_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pcd_pkg::ST_IDLE) |-> !r_pend_valid)
        else $error("A result is still pending while the sequencer is idle.");

    a_idle_marks_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pcd_pkg::ST_IDLE) |-> (r_seen == '0 && r_count == '0))
        else $error("Seen marks or result count were not cleared after a decomposition.");

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= pcd_pkg::CNT_W'(pcd_pkg::ELEMENTS))
        else $error("More results than elements were produced.");

    a_error_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.not_permutation) |-> (r_out.run_last && !r_out.cycle_end))
        else $error("An abandoned walk was not reported as the final result.");

endmodule
`default_nettype wire

// File: rtl/permutation_cycle_decompose.sv
// Top level of the permutation cycle decomposer: front queue and back sequencer.
//
//  Channel  Valid        Ready        Payload      Meaning
//  input    i_in_valid   o_in_ready   i_in_data    one element and image pair
//  output   o_out_valid  i_out_ready  o_out_data   one element of a cycle
//
// Load transactions pass through a four-entry queue that lets loads continue
// while the sequencer is busy. A decomposition scans each element in turn and
// handles every emitted element in a read state and then a step state (the
// table read is registered). Reset clears the moved marks, so the table reads
// as the identity. Output stalls hold the sequencer; a full queue holds the input.
`default_nettype none
module permutation_cycle_decompose (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire pcd_pkg::t_in_data  i_in_data,
    output logic                    o_in_ready,
    output logic                    o_out_valid,
    output pcd_pkg::t_out_data      o_out_data,
    input  wire logic               i_out_ready
);

    logic          cmd_valid;
    logic          cmd_ready;
    pcd_pkg::t_cmd cmd;

    pcd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_ready  (o_in_ready),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_ready (cmd_ready)
    );

    pcd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_ready (cmd_ready),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_ready (i_out_ready)
    );

endmodule
`default_nettype wire

// File: sim/permutation_cycle_decompose_test.sv
// Self-checking testbench for the permutation cycle decomposer, with a predictor and random traffic.
module permutation_cycle_decompose_test;

    localparam int QUIET_START  = 400;
    localparam int QUIET_END    = 800;
    localparam int HOLD_AT      = 150;
    localparam int HOLD_LEN     = 120;
    localparam int DRAIN_CYCLES = 4 * pcd_pkg::ELEMENTS + 20;
    localparam int RANDOM_LOADS = 96;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    pcd_pkg::t_in_data  i_in_data = '0;
    logic               o_in_ready;
    logic               o_out_valid;
    pcd_pkg::t_out_data o_out_data;
    logic               i_out_ready = 1'b0;

    pcd_pkg::t_in_data  pending_loads[$];
    pcd_pkg::t_out_data expected_cycles[$];
    pcd_pkg::t_elem     image_map[pcd_pkg::ELEMENTS];
    bit                 visited[pcd_pkg::ELEMENTS];
    int                 failures = 0;
    int                 cycle = 0;
    int                 hold_left = 0;

    permutation_cycle_decompose dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_ready (i_out_ready)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic bit idle_now();
        if (cycle >= QUIET_START && cycle < QUIET_END) begin
            return 1'b0;
        end
        return $urandom_range(99) < 7;
    endfunction

    function automatic void clear_map();
        for (int i = 0; i < pcd_pkg::ELEMENTS; i++) begin
            image_map[i] = pcd_pkg::t_elem'(i);
            visited[i]   = 1'b0;
        end
    endfunction

    function automatic pcd_pkg::t_out_data cycle_entry(int value, bit closes, bit abandoned);
        pcd_pkg::t_out_data entry;
        entry.cycle_value     = pcd_pkg::t_elem'(value);
        entry.cycle_end       = closes;
        entry.run_last        = 1'b0;
        entry.not_permutation = abandoned;
        return entry;
    endfunction

    function automatic void predict_decomposition(pcd_pkg::t_in_data item);
        pcd_pkg::t_out_data found[$];
        pcd_pkg::t_out_data tail;
        int                 pos;
        int                 nxt;
        bit                 failed;
        image_map[item.element] = item.image;
        if (!item.load_last) begin
            return;
        end
        failed = 1'b0;
        for (int s = 0; s < pcd_pkg::ELEMENTS && !failed; s++) begin
            if (image_map[s] != pcd_pkg::t_elem'(s) && !visited[s]) begin
                pos = s;
                forever begin
                    nxt = int'(image_map[pos]);
                    visited[pos] = 1'b1;
                    if (nxt == s) begin
                        found.insert(found.size(), cycle_entry(pos, 1'b1, 1'b0));
                        break;
                    end
                    if (found.size() + 1 >= pcd_pkg::ELEMENTS) begin
                        found.insert(found.size(), cycle_entry(pos, 1'b0, 1'b1));
                        failed = 1'b1;
                        break;
                    end
                    found.insert(found.size(), cycle_entry(pos, 1'b0, 1'b0));
                    pos = nxt;
                end
            end
        end
        if (found.size() > 0) begin
            tail = found[found.size() - 1];
            tail.run_last = 1'b1;
            found[found.size() - 1] = tail;
        end
        foreach (found[k]) begin
            expected_cycles.insert(expected_cycles.size(), found[k]);
        end
        clear_map();
    endfunction

    function automatic void check_cycle_element(pcd_pkg::t_out_data got);
        pcd_pkg::t_out_data want;
        if (expected_cycles.size() == 0) begin
            $display("%0t: unexpected transaction, expected none, actual %h", $time, got);
            failures++;
            return;
        end
        want = expected_cycles.pop_front();
        if (got.cycle_value != want.cycle_value) begin
            $display("%0t: cycle_value expected %0d actual %0d", $time,
                     want.cycle_value, got.cycle_value);
            failures++;
        end
        if (got.cycle_end != want.cycle_end) begin
            $display("%0t: cycle_end expected %b actual %b", $time, want.cycle_end, got.cycle_end);
            failures++;
        end
        if (got.run_last != want.run_last) begin
            $display("%0t: run_last expected %b actual %b", $time, want.run_last, got.run_last);
            failures++;
        end
        if (got.not_permutation != want.not_permutation) begin
            $display("%0t: not_permutation expected %b actual %b", $time,
                     want.not_permutation, got.not_permutation);
            failures++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            cycle <= cycle + 1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_map();
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                predict_decomposition(i_in_data);
            end
            if (!i_in_valid || o_in_ready) begin
                if (pending_loads.size() > 0 && !idle_now()) begin
                    i_in_valid <= 1'b1;
                    i_in_data  <= pending_loads.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                check_cycle_element(o_out_data);
            end
            if (hold_left > 0) begin
                hold_left   <= hold_left - 1;
                i_out_ready <= 1'b0;
            end else if (cycle == HOLD_AT) begin
                hold_left   <= HOLD_LEN;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= !idle_now();
            end
        end
    end

    function automatic void add_pair(int element, int image, bit last);
        pcd_pkg::t_in_data item;
        item.element   = pcd_pkg::t_elem'(element);
        item.image     = pcd_pkg::t_elem'(image);
        item.load_last = last;
        pending_loads.insert(pending_loads.size(), item);
    endfunction

    function automatic void add_random_permutation();
        int perm[pcd_pkg::ELEMENTS];
        int order[pcd_pkg::ELEMENTS];
        int picks[$];
        int swaps;
        int a;
        int b;
        int t;
        bit drop_one;
        for (int i = 0; i < pcd_pkg::ELEMENTS; i++) begin
            perm[i]  = i;
            order[i] = i;
        end
        swaps = ($urandom_range(9) == 0) ? 40 : $urandom_range(1, 6);
        for (int k = 0; k < swaps; k++) begin
            a = $urandom_range(pcd_pkg::ELEMENTS - 1);
            b = $urandom_range(pcd_pkg::ELEMENTS - 1);
            t = perm[a];
            perm[a] = perm[b];
            perm[b] = t;
        end
        for (int i = pcd_pkg::ELEMENTS - 1; i > 0; i--) begin
            a = $urandom_range(i);
            t = order[a];
            order[a] = order[i];
            order[i] = t;
        end
        // Now and then one moved pair is left out so that the table is no bijection.
        drop_one = $urandom_range(7) == 0;
        foreach (order[i]) begin
            if (perm[order[i]] != order[i] && drop_one) begin
                drop_one = 1'b0;
            end else if (perm[order[i]] != order[i] || $urandom_range(3) == 0) begin
                picks.insert(picks.size(), order[i]);
            end
        end
        if (picks.size() == 0) begin
            picks.insert(picks.size(), order[0]);
        end
        foreach (picks[j]) begin
            if ($urandom_range(9) == 0) begin
                add_pair(picks[j], $urandom_range(pcd_pkg::ELEMENTS - 1), 1'b0);
            end
            add_pair(picks[j], perm[picks[j]], j == picks.size() - 1);
        end
    endfunction

    function automatic void add_random_noise();
        int count;
        count = $urandom_range(1, 8);
        for (int j = 0; j < count; j++) begin
            add_pair($urandom_range(pcd_pkg::ELEMENTS - 1), $urandom_range(pcd_pkg::ELEMENTS - 1),
                     j == count - 1);
        end
    endfunction

    initial begin
        int directed;
        add_pair(3, 3, 1'b1);
        add_pair(0, 15, 1'b0);
        add_pair(15, 0, 1'b1);
        add_pair(2, 7, 1'b0);
        add_pair(9, 7, 1'b1);
        add_pair(4, 9, 1'b0);
        add_pair(4, 5, 1'b0);
        add_pair(5, 4, 1'b1);
        for (int i = 0; i < pcd_pkg::ELEMENTS; i++) begin
            add_pair(i, (i + 1) % pcd_pkg::ELEMENTS, i == pcd_pkg::ELEMENTS - 1);
        end
        directed = pending_loads.size();
        while (pending_loads.size() - directed < RANDOM_LOADS) begin
            if ($urandom_range(99) < 85) begin
                add_random_permutation();
            end else begin
                add_random_noise();
            end
        end
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        do begin
            @(posedge i_clk);
        end while (pending_loads.size() > 0 || i_in_valid);
        while (expected_cycles.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (failures == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// File: files.f
rtl/pcd_pkg.sv
rtl/pcd_front.sv
rtl/pcd_back.sv
rtl/permutation_cycle_decompose.sv
sim/permutation_cycle_decompose_test.sv
